### src/wat_pkg.sv
// wat_pkg: shared types and constants for the weekly alarm table matcher
// field widths, command codes, sequencer states and the stored entry layout
// no dependencies
`default_nettype none

package wat_pkg;

  // payload field widths
  localparam int CMD_W     = 3;
  localparam int IDX_W     = 6;
  localparam int HOUR_W    = 5;
  localparam int MIN_W     = 6;
  localparam int WD_W      = 3;
  localparam int DAYS_W    = 7;
  localparam int CNT_OUT_W = 7;

  // command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_CHECK  = 3'd0,
    CMD_ADD    = 3'd1,
    CMD_SET    = 3'd2,
    CMD_DELETE = 3'd3,
    CMD_GET    = 3'd4
  } cmd_t;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_DEL,
    S_GET,
    S_OUT
  } state_t;

  // one stored alarm
  typedef struct packed {
    logic [HOUR_W-1:0] hour;
    logic [MIN_W-1:0]  minute;
    logic [DAYS_W-1:0] days;
  } entry_t;

endpackage

`default_nettype wire

### src/wat_if.sv
// wat_if: valid/ready channel interfaces for command beats and result beats
// depends on wat_pkg for the field widths
`default_nettype none

interface wat_cmd_if;
  import wat_pkg::*;

  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [IDX_W-1:0]  entry_index;
  logic [HOUR_W-1:0] now_hour;
  logic [MIN_W-1:0]  now_minute;
  logic [WD_W-1:0]   weekday;
  logic [HOUR_W-1:0] alarm_hour;
  logic [MIN_W-1:0]  alarm_minute;
  logic [DAYS_W-1:0] alarm_days;

  modport source (
    output valid, command, entry_index, now_hour, now_minute, weekday,
           alarm_hour, alarm_minute, alarm_days,
    input  ready
  );

  modport sink (
    input  valid, command, entry_index, now_hour, now_minute, weekday,
           alarm_hour, alarm_minute, alarm_days,
    output ready
  );
endinterface

interface wat_res_if;
  import wat_pkg::*;

  logic                 valid;
  logic                 ready;
  logic                 ok;
  logic                 alarm_due;
  logic [HOUR_W-1:0]    read_hour;
  logic [MIN_W-1:0]     read_minute;
  logic [DAYS_W-1:0]    read_days;
  logic [CNT_OUT_W-1:0] live_count;

  modport source (
    output valid, ok, alarm_due, read_hour, read_minute, read_days, live_count,
    input  ready
  );

  modport sink (
    input  valid, ok, alarm_due, read_hour, read_minute, read_days, live_count,
    output ready
  );
endinterface

`default_nettype wire

### src/weekly_alarm_table_matcher.sv
// weekly_alarm_table_matcher: alarm table with check, add, set, delete and get
// depends on wat_pkg and the channel interfaces in wat_if
//
//   channel | dir | beat carries
//   --------+-----+-----------------------------------------------------------
//   cmd     | in  | command, entry_index, now_hour/minute, weekday, alarm fields
//   res     | out | ok, alarm_due, read_hour/minute/days, live_count
//
// one command at a time: cmd.ready is high only while the sequencer is idle
// check goes through S_EXEC, S_SCAN and S_OUT, reading each live entry in S_SCAN:
// the single table read port delivers one entry per cycle
// add, set and refused go to S_OUT; get and delete first do one table read
// the result register holds its beat until res.ready, then the sequencer idles
// synchronous reset empties the table (count to zero); entries need no clearing
`default_nettype none

module weekly_alarm_table_matcher #(
  parameter int MAX_ALARMS = 64
) (
  input  logic             clk,
  input  logic             rst,
  wat_cmd_if.sink          cmd,
  wat_res_if.source        res
);
  import wat_pkg::*;

  localparam int CW = $clog2(MAX_ALARMS + 1);
  localparam int AW = (MAX_ALARMS > 1) ? $clog2(MAX_ALARMS) : 1;
  localparam int XW = (CW > IDX_W) ? CW : IDX_W;
  localparam int LW = (CW > CNT_OUT_W) ? CW : CNT_OUT_W;

  // sequencer and count
  state_t            state;
  state_t            state_next;
  logic [CW-1:0]     count;
  logic [CW-1:0]     scan_idx;
  logic              rd_vld;

  // captured command
  logic [CMD_W-1:0]  cmd_q;
  logic [IDX_W-1:0]  idx_q;
  logic [HOUR_W-1:0] hour_q;
  logic [MIN_W-1:0]  min_q;
  logic [WD_W-1:0]   wd_q;
  entry_t            entry_q;

  // result register
  logic              res_ok;
  logic              res_due;
  entry_t            res_entry;

  // table memory
  entry_t            mem [MAX_ALARMS];
  entry_t            rd_data;
  logic              mem_re;
  logic              mem_we;
  logic [AW-1:0]     rd_addr;
  logic [AW-1:0]     wr_addr;
  entry_t            wr_data;

  // decode helpers
  logic [XW-1:0]     idx_ext;
  logic [XW-1:0]     cnt_ext;
  logic              in_range;
  logic              has_room;
  logic [AW-1:0]     idx_addr;
  logic [CW-1:0]     last_idx;
  logic              scan_more;
  logic [DAYS_W-1:0] day_mask;
  logic              hit;
  logic              ok_exec;
  logic [LW-1:0]     count_ext;

  assign idx_ext   = XW'(idx_q);
  assign cnt_ext   = XW'(count);
  assign in_range  = idx_ext < cnt_ext;
  assign has_room  = count < CW'(MAX_ALARMS);
  assign idx_addr  = idx_ext[AW-1:0];
  assign last_idx  = count - CW'(1);
  assign scan_more = scan_idx < count;

  // weekday zero wraps to a shift past the mask and selects no bit
  assign day_mask  = DAYS_W'(1) << (wd_q - WD_W'(1));
  assign hit       = (rd_data.hour == hour_q) && (rd_data.minute == min_q) &&
                     ((rd_data.days & day_mask) != '0);

  // channel handshakes and result payload
  assign cmd.ready       = (state == S_IDLE);
  assign res.valid       = (state == S_OUT);
  assign res.ok          = res_ok;
  assign res.alarm_due   = res_due;
  assign res.read_hour   = res_entry.hour;
  assign res.read_minute = res_entry.minute;
  assign res.read_days   = res_entry.days;
  assign count_ext       = LW'(count);
  assign res.live_count  = count_ext[CNT_OUT_W-1:0];

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and table port control
  always_comb begin
    state_next = state;
    mem_re     = 1'b0;
    mem_we     = 1'b0;
    rd_addr    = '0;
    wr_addr    = '0;
    wr_data    = entry_q;
    ok_exec    = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (cmd.valid) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        state_next = S_OUT;
        unique case (cmd_q)
          CMD_CHECK: begin
            ok_exec    = 1'b1;
            state_next = S_SCAN;
          end
          CMD_ADD: begin
            ok_exec = has_room;
            mem_we  = has_room;
            wr_addr = count[AW-1:0];
          end
          CMD_SET: begin
            ok_exec = in_range;
            mem_we  = in_range;
            wr_addr = idx_addr;
          end
          CMD_DELETE: begin
            ok_exec = in_range;
            if (in_range) begin
              mem_re     = 1'b1;
              rd_addr    = last_idx[AW-1:0];
              state_next = S_DEL;
            end
          end
          CMD_GET: begin
            ok_exec = in_range;
            if (in_range) begin
              mem_re     = 1'b1;
              rd_addr    = idx_addr;
              state_next = S_GET;
            end
          end
          default: begin
            ok_exec = 1'b0;
          end
        endcase
      end
      S_SCAN: begin
        if (scan_more) begin
          mem_re  = 1'b1;
          rd_addr = scan_idx[AW-1:0];
        end else if (!rd_vld) begin
          state_next = S_OUT;
        end
      end
      S_DEL: begin
        // last entry fills the freed slot
        mem_we     = 1'b1;
        wr_addr    = idx_addr;
        wr_data    = rd_data;
        state_next = S_OUT;
      end
      S_GET: begin
        state_next = S_OUT;
      end
      S_OUT: begin
        if (res.ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // table storage, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      rd_data <= mem[rd_addr];
    end
  end

  // live count and scan read tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= (state == S_SCAN) && scan_more;
      if (state == S_EXEC && cmd_q == CMD_ADD && has_room) begin
        count <= count + CW'(1);
      end else if (state == S_DEL) begin
        count <= last_idx;
      end
    end
  end

  // command capture and result datapath
  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      cmd_q          <= cmd.command;
      idx_q          <= cmd.entry_index;
      hour_q         <= cmd.now_hour;
      min_q          <= cmd.now_minute;
      wd_q           <= cmd.weekday;
      entry_q.hour   <= cmd.alarm_hour;
      entry_q.minute <= cmd.alarm_minute;
      entry_q.days   <= cmd.alarm_days;
    end
    if (state == S_EXEC) begin
      res_ok    <= ok_exec;
      res_due   <= 1'b0;
      res_entry <= '0;
      scan_idx  <= '0;
    end
    if (state == S_SCAN) begin
      if (scan_more) begin
        scan_idx <= scan_idx + CW'(1);
      end
      if (rd_vld && hit) begin
        res_due <= 1'b1;
      end
    end
    if (state == S_GET) begin
      res_entry <= rd_data;
    end
  end

  // count never passes the table size
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_ALARMS))
    else $error("live count above table size");

  // count moves only on a granted add or a delete write
  a_count_src: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && count != $past(count)) |->
      ($past(state) == S_EXEC || $past(state) == S_DEL))
    else $error("live count changed outside add or delete");

  // never open for a command while a result waits
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    !(cmd.ready && res.valid))
    else $error("command accepted with a result pending");

  // a due flag only comes with a successful check
  a_due_ok: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.alarm_due) |-> (res.ok && cmd_q == CMD_CHECK))
    else $error("alarm due reported outside a check");

  // scan pointer never passes the live count
  a_scan_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (scan_idx <= count))
    else $error("scan pointer beyond live count");

endmodule

`default_nettype wire
